// ===== design/wts_pkg.sv =====
// shared constants, control word type and microcode program for the temperature slope block
package wts_pkg;

   // history ring, DEPTH must be a power of two
   localparam int DEPTH     = 64;
   localparam int WINDOW    = 4;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(WINDOW + 1);

   localparam int SAMPLE_W  = 14;
   localparam int LAG_W     = 6;
   localparam int SCALE_W   = 16;
   localparam int RATE_W    = 16;
   localparam int DIFF_W    = 15;
   localparam int AVG_W     = 15;
   localparam int SUM_W     = SAMPLE_W + CNT_W;
   localparam int MAG_W     = SUM_W;
   localparam int RECIP_W   = MAG_W + 1;
   localparam int QP_W      = MAG_W + RECIP_W;
   localparam int QC_W      = MAG_W + CNT_W;
   localparam int AGE_W     = ((ADDR_W > LAG_W) ? ADDR_W : LAG_W) + 1;
   localparam int PROD_W    = DIFF_W + SCALE_W + 1;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;
   localparam int STEP_W    = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LAG   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE = 1'd1;

   // register reset values
   localparam logic [LAG_W-1:0]   LAG_RESET   = 6'd10;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

   // jump conditions
   localparam logic [2:0] COND_NEXT   = 3'd0;
   localparam logic [2:0] COND_ALWAYS = 3'd1;
   localparam logic [2:0] COND_NO_REQ = 3'd2;
   localparam logic [2:0] COND_MORE   = 3'd3;
   localparam logic [2:0] COND_BUSY   = 3'd4;

   // program steps
   localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
   localparam logic [STEP_W-1:0] STEP_NOW_LOOP  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_NOW_TAIL  = 4'd2;
   localparam logic [STEP_W-1:0] STEP_NOW_MUL   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_NOW_QC    = 4'd4;
   localparam logic [STEP_W-1:0] STEP_NOW_FIX   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_PAST_LOOP = 4'd6;
   localparam logic [STEP_W-1:0] STEP_PAST_TAIL = 4'd7;
   localparam logic [STEP_W-1:0] STEP_PAST_MUL  = 4'd8;
   localparam logic [STEP_W-1:0] STEP_PAST_QC   = 4'd9;
   localparam logic [STEP_W-1:0] STEP_PAST_FIX  = 4'd10;
   localparam logic [STEP_W-1:0] STEP_DIFF      = 4'd11;
   localparam logic [STEP_W-1:0] STEP_MUL       = 4'd12;
   localparam logic [STEP_W-1:0] STEP_HOLD      = 4'd13;
   localparam logic [STEP_W-1:0] STEP_OUT       = 4'd14;

   typedef struct packed {
      logic              idle;
      logic              clr;
      logic              rd;
      logic              base_lag;
      logic              div_mul;
      logic              div_qc;
      logic              div_fix;
      logic              dst_past;
      logic              diff;
      logic              mul;
      logic              out;
      logic [2:0]        cond;
      logic [STEP_W-1:0] target;
   } ctrl_type;

   typedef struct packed {
      logic req_fire;
      logic last_read;
      logic out_busy;
   } flags_type;

   function automatic ctrl_type ucode(input logic [STEP_W-1:0] step);
      ctrl_type c;
      c = '0;
      case (step)
         STEP_IDLE: begin
            c.idle   = 1'b1;
            c.clr    = 1'b1;
            c.cond   = COND_NO_REQ;
            c.target = STEP_IDLE;
         end
         STEP_NOW_LOOP: begin
            c.rd     = 1'b1;
            c.cond   = COND_MORE;
            c.target = STEP_NOW_LOOP;
         end
         STEP_NOW_TAIL: c.cond = COND_NEXT;
         STEP_NOW_MUL:  c.div_mul = 1'b1;
         STEP_NOW_QC:   c.div_qc = 1'b1;
         STEP_NOW_FIX: begin
            c.div_fix = 1'b1;
            c.clr     = 1'b1;
         end
         STEP_PAST_LOOP: begin
            c.rd       = 1'b1;
            c.base_lag = 1'b1;
            c.cond     = COND_MORE;
            c.target   = STEP_PAST_LOOP;
         end
         STEP_PAST_TAIL: c.cond = COND_NEXT;
         STEP_PAST_MUL:  c.div_mul = 1'b1;
         STEP_PAST_QC:   c.div_qc = 1'b1;
         STEP_PAST_FIX: begin
            c.div_fix  = 1'b1;
            c.dst_past = 1'b1;
         end
         STEP_DIFF: c.diff = 1'b1;
         STEP_MUL:  c.mul = 1'b1;
         STEP_HOLD: begin
            c.cond   = COND_BUSY;
            c.target = STEP_HOLD;
         end
         STEP_OUT: begin
            c.out    = 1'b1;
            c.cond   = COND_ALWAYS;
            c.target = STEP_IDLE;
         end
         default: begin
            c.cond   = COND_ALWAYS;
            c.target = STEP_IDLE;
         end
      endcase
      return c;
   endfunction

endpackage

// ===== design/wts_hist.sv =====
// sample history ring with per-entry valid bits and registered read
module wts_hist
   import wts_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [SAMPLE_W-1:0] wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic [SAMPLE_W-1:0] rd_data
);

   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]    valid_ff;
   logic [SAMPLE_W-1:0] rd_mem_ff;
   logic                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_mem_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // never-written slots read as empty
   assign rd_data = rd_valid_ff ? rd_mem_ff : '0;

endmodule

// ===== design/wts_seq.sv =====
// microcode step counter and control store
module wts_seq
   import wts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   output ctrl_type  ctl
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              take_jump;

   assign ctl = ucode(step_ff);

   always_comb begin
      case (ctl.cond)
         COND_NEXT:   take_jump = 1'b0;
         COND_ALWAYS: take_jump = 1'b1;
         COND_NO_REQ: take_jump = !flags.req_fire;
         COND_MORE:   take_jump = !flags.last_read;
         COND_BUSY:   take_jump = flags.out_busy;
         default:     take_jump = 1'b1;
      endcase
      step_in = take_jump ? ctl.target : step_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== design/windowed_temperature_slope_top.sv =====
// windowed temperature slope: history ring, two window averages, scaled and saturated rate
//
//   port group   direction   handshake           payload
//   req_*        in          req_valid/req_stall req_sample (14b signed)
//   rsp_*        out         rsp_valid/rsp_stall rsp_rate, rsp_difference, rsp_updated
//   csr_*        in          csr_write           csr_index, csr_data (write only)
//
// each sample runs through the steps of the microcode program in order:
// the accept step, then per average one memory read per window element, a step for the
// last read to land, a reciprocal multiply, a quotient check and a correction with sign;
// then the difference, the rate multiply, a wait step and the output load.
// reset is synchronous; it clears the ring valid bits, the write pointer, the held rate
// and restores lag_periods = 10 and rate_scale = 256.
// a finished transfer sits in the output register while the next sample is taken; the wait
// step ahead of the output load repeats while that register is still stalled.
module windowed_temperature_slope_top
   import wts_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [SAMPLE_W-1:0]  req_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [RATE_W-1:0]    rsp_rate,
   output logic signed [DIFF_W-1:0]    rsp_difference,
   output logic                        rsp_updated,
   input  logic                        csr_write,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]            csr_data
);

   // saturation limits of the rate
   localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((1 <<< (RATE_W - 1)) - 1);
   localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(-(1 <<< (RATE_W - 1)));

   ctrl_type  ctl;
   flags_type flags;
   logic      req_fire;

   // configuration registers
   logic [LAG_W-1:0]   lag_ff;
   logic [SCALE_W-1:0] scale_ff;

   // ring addressing
   logic [ADDR_W-1:0]   wp_ff;
   logic [ADDR_W-1:0]   newest_ff;
   logic [CNT_W-1:0]    idx_ff;
   logic [AGE_W-1:0]    age;
   logic [ADDR_W-1:0]   rd_addr;
   logic [SAMPLE_W-1:0] rd_data;
   logic                rd_pend_ff;

   // window accumulation
   logic signed [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0]        count_ff;

   // reciprocal divide
   logic [RECIP_W-1:0] recip_tab [WINDOW + 1];
   logic [MAG_W-1:0]   mag;
   logic [MAG_W-1:0]   mag_ff;
   logic [QP_W-1:0]    qprod_ff;
   logic [MAG_W-1:0]   q_ff;
   logic [QC_W-1:0]    qc_ff;
   logic [QC_W-1:0]    rem;
   logic [MAG_W-1:0]   q_fix;
   logic [MAG_W-1:0]   q_signed;
   logic [AVG_W-1:0]   avg_in;

   // averages, difference and rate
   logic signed [AVG_W-1:0]  now_avg_ff;
   logic signed [AVG_W-1:0]  past_avg_ff;
   logic [AVG_W:0]           diff_wide;
   logic signed [DIFF_W-1:0] diff_ff;
   logic                     upd_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] shifted;
   logic signed [RATE_W-1:0] sat_rate;
   logic signed [RATE_W-1:0] held_rate_ff;

   // output register
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [RATE_W-1:0] rsp_rate_ff;
   logic signed [DIFF_W-1:0] rsp_diff_ff;
   logic                     rsp_upd_ff;

   // ---------------- control ----------------

   assign req_stall = !ctl.idle;
   assign req_fire  = req_valid && ctl.idle;

   assign flags.req_fire  = req_fire;
   assign flags.last_read = (idx_ff == CNT_W'(WINDOW - 1));
   assign flags.out_busy  = rsp_valid_ff && rsp_stall;

   wts_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   // ---------------- configuration ----------------

   always_ff @(posedge clock) begin
      if (reset) begin
         lag_ff   <= LAG_RESET;
         scale_ff <= SCALE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LAG:   lag_ff   <= csr_data[LAG_W-1:0];
            CSR_SCALE: scale_ff <= csr_data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- history ring ----------------

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
      end else if (req_fire) begin
         wp_ff <= wp_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         newest_ff <= wp_ff;
      end
   end

   // age wraps modulo the ring size, so only the low address bits matter
   assign age     = (ctl.base_lag ? AGE_W'(lag_ff) : '0) + AGE_W'(idx_ff);
   assign rd_addr = newest_ff - age[ADDR_W-1:0];

   wts_hist u_hist (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_fire),
      .wr_addr (wp_ff),
      .wr_data (req_sample),
      .rd_en   (ctl.rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------- window sum ----------------

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= ctl.rd;
      end
   end

   // read data lands in the step after its address; empty slots are skipped
   always_ff @(posedge clock) begin
      if (ctl.clr) begin
         idx_ff   <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (ctl.rd) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
         if (rd_pend_ff && (rd_data != '0)) begin
            sum_ff   <= sum_ff + {{CNT_W{rd_data[SAMPLE_W-1]}}, rd_data};
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   // ---------------- divide by count ----------------

   // floor(2^MAG_W / c): the quotient estimate is at most one short
   assign recip_tab[0] = '0;
   for (genvar g = 1; g <= WINDOW; g++) begin : g_recip
      localparam logic [RECIP_W-1:0] RVAL = RECIP_W'((64'd1 << MAG_W) / g);
      assign recip_tab[g] = RVAL;
   end

   assign mag = sum_ff[SUM_W-1] ? MAG_W'(-sum_ff) : MAG_W'(sum_ff);

   always_ff @(posedge clock) begin
      if (ctl.div_mul) begin
         mag_ff   <= mag;
         qprod_ff <= QP_W'(mag * recip_tab[count_ff]);
      end
      if (ctl.div_qc) begin
         q_ff  <= qprod_ff[MAG_W +: MAG_W];
         qc_ff <= QC_W'(qprod_ff[MAG_W +: MAG_W] * count_ff);
      end
   end

   // remainder check, then sign back; truncation toward zero falls out
   always_comb begin
      rem      = {{CNT_W{1'b0}}, mag_ff} - qc_ff;
      q_fix    = q_ff + MAG_W'(rem >= QC_W'(count_ff));
      q_signed = sum_ff[SUM_W-1] ? (~q_fix + MAG_W'(1)) : q_fix;
      avg_in   = (count_ff == '0) ? '0 : q_signed[AVG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.div_fix) begin
         if (ctl.dst_past) begin
            past_avg_ff <= avg_in;
         end else begin
            now_avg_ff <= avg_in;
         end
      end
   end

   // ---------------- difference and rate ----------------

   assign diff_wide = {now_avg_ff[AVG_W-1], now_avg_ff} - {past_avg_ff[AVG_W-1], past_avg_ff};

   always_ff @(posedge clock) begin
      if (ctl.diff) begin
         upd_ff  <= (now_avg_ff != '0) && (past_avg_ff != '0);
         diff_ff <= ((now_avg_ff != '0) && (past_avg_ff != '0)) ?
                    diff_wide[DIFF_W-1:0] : '0;
      end
      if (ctl.mul) begin
         prod_ff <= diff_ff * $signed({1'b0, scale_ff});
      end
   end

   // arithmetic shift floors, then clamp to 16 bits
   always_comb begin
      shifted = prod_ff >>> 8;
      if (shifted > SAT_HI) begin
         sat_rate = SAT_HI[RATE_W-1:0];
      end else if (shifted < SAT_LO) begin
         sat_rate = SAT_LO[RATE_W-1:0];
      end else begin
         sat_rate = shifted[RATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_rate_ff <= '0;
      end else if (ctl.out && upd_ff) begin
         held_rate_ff <= sat_rate;
      end
   end

   // ---------------- output register ----------------

   assign rsp_valid_in = ctl.out ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out) begin
         rsp_rate_ff <= upd_ff ? sat_rate : held_rate_ff;
         rsp_diff_ff <= diff_ff;
         rsp_upd_ff  <= upd_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rate       = rsp_rate_ff;
   assign rsp_difference = rsp_diff_ff;
   assign rsp_updated    = rsp_upd_ff;

   // ---------------- checks ----------------

   // one sample at a time: a transfer in closes the input for the next cycle
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken twice in a row");

   // the output register is never loaded over a transfer still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.out |-> !rsp_valid_ff)
      else $error("output register overwritten");

   // a result without an update carries a zero difference
   a_diff_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_updated |-> rsp_difference == '0)
      else $error("difference set without update");

   // the divider never sees a count beyond the window
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      ctl.div_fix |-> count_ff <= CNT_W'(WINDOW))
      else $error("window count out of range");

endmodule
